@@ hw/rtl/pwfe_pkg.sv @@
// ----------------------------------------------------------------------------
// Plane-wave field evaluator package
// Shared types, constants and the CORDIC angle table.
// ----------------------------------------------------------------------------
package pwfe_pkg;

    localparam int SINE_ITERS_DEF = 16;
    localparam int ANG_TAB_LEN    = 24;
    localparam int DIV_STEPS      = 64;
    localparam int FIFO_DEPTH     = 4;

    localparam logic [2:0] REG_FREQUENCY  = 3'd0;
    localparam logic [2:0] REG_WAVELENGTH = 3'd1;
    localparam logic [2:0] REG_AMP_E      = 3'd2;
    localparam logic [2:0] REG_AMP_B      = 3'd3;
    localparam logic [2:0] REG_PHASE      = 3'd4;

    localparam logic [31:0] FREQ_RST  = 32'd65536;
    localparam logic [31:0] WAVE_RST  = 32'd65536;
    localparam logic [15:0] AMP_RST   = 16'd256;
    localparam logic [15:0] PHASE_RST = 16'd0;

    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [32:0] QUARTER     = 33'sd1073741824;
    localparam logic signed [32:0] HALF        = 33'sd2147483648;

    typedef struct packed {
        logic [31:0] frequency;
        logic [31:0] wavelength;
        logic [15:0] amp_e;
        logic [15:0] amp_b;
        logic [15:0] phase_turns;
    } cfg_t;

    function automatic logic [31:0] ang_tab(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2F9;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

@@ hw/rtl/plane_wave_field_eval_core.sv @@
// ----------------------------------------------------------------------------
// Plane-wave field evaluator
// Computes E and B of a plane sine wave at a given time and position.
// ----------------------------------------------------------------------------
// Throughput is one word per cycle while in_stall and out_stall are low; the
// front and back pipelines are fully staged. The front end registers the multiply,
// 64 divider steps and phase sum; the queue then passes angles to the back end.
// Reset clears all valid flags and the queue and loads the default registers.
module plane_wave_field_eval_core #(
    parameter int SINE_ITERS = pwfe_pkg::SINE_ITERS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [31:0]        time_val,
    input  logic signed [31:0] position,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [16:0] e_field,
    output logic signed [16:0] b_field,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    pwfe_pkg::cfg_t cfg_reg;
    logic           f_en;
    logic           push;
    logic [31:0]    angle;
    logic           pop;
    logic [31:0]    q_data;
    logic           q_full;
    logic           q_empty;

    assign cfg_ready = 1'b1;
    assign f_en      = !q_full;
    assign in_stall  = !f_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frequency   <= pwfe_pkg::FREQ_RST;
            cfg_reg.wavelength  <= pwfe_pkg::WAVE_RST;
            cfg_reg.amp_e       <= pwfe_pkg::AMP_RST;
            cfg_reg.amp_b       <= pwfe_pkg::AMP_RST;
            cfg_reg.phase_turns <= pwfe_pkg::PHASE_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                pwfe_pkg::REG_FREQUENCY:
                begin
                    if (cfg_data != 32'd0)
                    begin
                        cfg_reg.frequency <= cfg_data;
                    end
                end
                pwfe_pkg::REG_WAVELENGTH:
                begin
                    if (cfg_data != 32'd0)
                    begin
                        cfg_reg.wavelength <= cfg_data;
                    end
                end
                pwfe_pkg::REG_AMP_E:
                begin
                    if (cfg_data[15:0] != 16'd0)
                    begin
                        cfg_reg.amp_e <= cfg_data[15:0];
                    end
                end
                pwfe_pkg::REG_AMP_B:
                begin
                    if (cfg_data[15:0] != 16'd0)
                    begin
                        cfg_reg.amp_b <= cfg_data[15:0];
                    end
                end
                pwfe_pkg::REG_PHASE:
                begin
                    cfg_reg.phase_turns <= cfg_data[15:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    pwfe_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .en       (f_en),
        .in_valid (in_valid),
        .time_val (time_val),
        .position (position),
        .push     (push),
        .angle    (angle)
    );

    pwfe_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (angle),
        .pop   (pop),
        .rdata (q_data),
        .full  (q_full),
        .empty (q_empty)
    );

    pwfe_back #(
        .SINE_ITERS (SINE_ITERS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_empty   (q_empty),
        .q_data    (q_data),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .e_field   (e_field),
        .b_field   (b_field)
    );

endmodule

@@ hw/rtl/pwfe_front.sv @@
// ----------------------------------------------------------------------------
// Phase front end
// Accepts time and position words and forms the phase angle in turns.
// ----------------------------------------------------------------------------
module pwfe_front (
    input  logic               clk,
    input  logic               rst_n,
    input  pwfe_pkg::cfg_t     cfg,
    input  logic               en,
    input  logic               in_valid,
    input  logic [31:0]        time_val,
    input  logic signed [31:0] position,
    output logic               push,
    output logic [31:0]        angle
);

    localparam int DS = pwfe_pkg::DIV_STEPS;

    logic              v_reg   [0:DS];
    logic [31:0]       ft_reg  [0:DS];
    logic              zn_reg  [0:DS];
    logic [31:0]       num_reg [0:DS];
    logic [31:0]       rem_reg [0:DS];
    logic [31:0]       quo_reg [0:DS];
    logic              va_reg;
    logic [31:0]       ang_reg;
    logic [31:0]       zmag;
    logic [31:0]       ang_next;
    logic [32:0]       r2     [0:DS-1];
    logic              ge     [0:DS-1];

    assign zmag = position[31] ? (32'd0 - position) : position;

    always_comb
    begin
        for (int k = 0; k < DS; k++)
        begin
            r2[k] = {rem_reg[k], num_reg[k][31]};
            ge[k] = (r2[k] >= {1'b0, cfg.wavelength});
        end
    end

    always_comb
    begin
        if (zn_reg[DS])
        begin
            ang_next = ft_reg[DS] + quo_reg[DS] + {cfg.phase_turns, 16'd0};
        end
        else
        begin
            ang_next = ft_reg[DS] - quo_reg[DS] + {cfg.phase_turns, 16'd0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= DS; k++)
            begin
                v_reg[k] <= 1'b0;
            end
            va_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int k = 0; k < DS; k++)
            begin
                v_reg[k+1] <= v_reg[k];
            end
            va_reg <= v_reg[DS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ft_reg[0]  <= 32'(cfg.frequency * time_val);
            zn_reg[0]  <= position[31];
            num_reg[0] <= zmag;
            rem_reg[0] <= 32'd0;
            quo_reg[0] <= 32'd0;
            for (int k = 0; k < DS; k++)
            begin
                ft_reg[k+1]  <= ft_reg[k];
                zn_reg[k+1]  <= zn_reg[k];
                num_reg[k+1] <= {num_reg[k][30:0], 1'b0};
                rem_reg[k+1] <= ge[k] ? 32'(r2[k] - {1'b0, cfg.wavelength}) : r2[k][31:0];
                quo_reg[k+1] <= {quo_reg[k][30:0], ge[k]};
            end
            ang_reg <= ang_next;
        end
    end

    assign push  = en & va_reg;
    assign angle = ang_reg;

endmodule

@@ hw/rtl/pwfe_queue.sv @@
// ----------------------------------------------------------------------------
// Phase queue
// Short FIFO of phase angles between the front end and the sine back end.
// ----------------------------------------------------------------------------
module pwfe_queue (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic [31:0] wdata,
    input  logic        pop,
    output logic [31:0] rdata,
    output logic        full,
    output logic        empty
);

    localparam int D  = pwfe_pkg::FIFO_DEPTH;
    localparam int AW = $clog2(D);

    logic [31:0]   mem [0:D-1];
    logic [AW-1:0] wp_reg;
    logic [AW-1:0] rp_reg;
    logic [AW:0]   cnt_reg;

    assign full  = (cnt_reg == (AW+1)'(D));
    assign empty = (cnt_reg == '0);
    assign rdata = mem[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (pop)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wp_reg] <= wdata;
        end
    end

endmodule

@@ hw/rtl/pwfe_back.sv @@
// ----------------------------------------------------------------------------
// Sine back end
// Folds the angle, runs a pipelined CORDIC and scales by both amplitudes.
// ----------------------------------------------------------------------------
module pwfe_back #(
    parameter int SINE_ITERS = pwfe_pkg::SINE_ITERS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  pwfe_pkg::cfg_t     cfg,
    input  logic               q_empty,
    input  logic [31:0]        q_data,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [16:0] e_field,
    output logic signed [16:0] b_field
);

    localparam int IT = (SINE_ITERS > pwfe_pkg::ANG_TAB_LEN) ?
                        pwfe_pkg::ANG_TAB_LEN : SINE_ITERS;
    localparam logic signed [33:0] SMAX = 34'sd32767;

    logic                en;
    logic                v_reg [0:IT];
    logic signed [33:0]  x_reg [0:IT];
    logic signed [33:0]  y_reg [0:IT];
    logic signed [32:0]  s_reg [0:IT];
    logic                vr_reg;
    logic signed [15:0]  sn_reg;
    logic                vm_reg;
    logic signed [32:0]  pe_reg;
    logic signed [32:0]  pb_reg;
    logic                vo_reg;
    logic signed [16:0]  e_reg;
    logic signed [16:0]  b_reg;
    logic signed [32:0]  s0;
    logic signed [32:0]  sf;
    logic signed [33:0]  yr;
    logic signed [15:0]  sn_next;
    logic signed [32:0]  e_tmp;
    logic signed [32:0]  b_tmp;

    assign en  = !(vo_reg && out_stall);
    assign pop = en && !q_empty;

    always_comb
    begin
        s0 = {q_data[31], q_data};
        if (s0 > pwfe_pkg::QUARTER)
        begin
            sf = pwfe_pkg::HALF - s0;
        end
        else if (s0 < -pwfe_pkg::QUARTER)
        begin
            sf = -pwfe_pkg::HALF - s0;
        end
        else
        begin
            sf = s0;
        end
    end

    always_comb
    begin
        yr = (y_reg[IT] + 34'sd16384) >>> 15;
        if (yr > SMAX)
        begin
            sn_next = 16'sd32767;
        end
        else if (yr < -SMAX)
        begin
            sn_next = -16'sd32767;
        end
        else
        begin
            sn_next = yr[15:0];
        end
    end

    assign e_tmp = (pe_reg + 33'sd16384) >>> 15;
    assign b_tmp = (pb_reg + 33'sd16384) >>> 15;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= IT; i++)
            begin
                v_reg[i] <= 1'b0;
            end
            vr_reg <= 1'b0;
            vm_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= !q_empty;
            for (int i = 0; i < IT; i++)
            begin
                v_reg[i+1] <= v_reg[i];
            end
            vr_reg <= v_reg[IT];
            vm_reg <= vr_reg;
            vo_reg <= vm_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= pwfe_pkg::CORDIC_GAIN;
            y_reg[0] <= 34'sd0;
            s_reg[0] <= sf;
            for (int i = 0; i < IT; i++)
            begin
                if (!s_reg[i][32])
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    s_reg[i+1] <= s_reg[i] - $signed({1'b0, pwfe_pkg::ang_tab(5'(i))});
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    s_reg[i+1] <= s_reg[i] + $signed({1'b0, pwfe_pkg::ang_tab(5'(i))});
                end
            end
            sn_reg <= sn_next;
            pe_reg <= $signed({1'b0, cfg.amp_e}) * sn_reg;
            pb_reg <= $signed({1'b0, cfg.amp_b}) * sn_reg;
            e_reg  <= e_tmp[16:0];
            b_reg  <= b_tmp[16:0];
        end
    end

    assign out_valid = vo_reg;
    assign e_field   = e_reg;
    assign b_field   = b_reg;

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Plane-wave field evaluator testbench
// Drives time and position words into the core, predicts each E and B word
// with an independent CORDIC phase-and-sine model, and checks every result
// in order under several configurations and idle/stall patterns.
// ----------------------------------------------------------------------------
module testbench;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [31:0]        time_val;
    logic signed [31:0] position;
    logic               out_valid;
    logic               out_stall;
    logic signed [16:0] e_field;
    logic signed [16:0] b_field;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_data;

    typedef struct packed {
        logic signed [16:0] e;
        logic signed [16:0] b;
    } fields_t;

    pwfe_pkg::cfg_t wave_cfg;
    fields_t        field_queue[$];
    int             error_count;
    int             send_idle_pct;
    int             recv_stall_pct;

    localparam logic [31:0] ANGLES [24] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};

    plane_wave_field_eval_core u_top (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic longint sine_of_turns(input logic [31:0] ang);
        longint s;
        longint x;
        longint y;
        longint nx;
        int     iters;
        s = longint'(ang);
        x = 64'sd652032874;
        y = 0;
        iters = (pwfe_pkg::SINE_ITERS_DEF > 24) ? 24 : pwfe_pkg::SINE_ITERS_DEF;
        if (s >= 64'sd2147483648)
            s -= 64'sd4294967296;
        if (s > 64'sd1073741824)
            s = 64'sd2147483648 - s;
        else if (s < -64'sd1073741824)
            s = -64'sd2147483648 - s;
        for (int i = 0; i < iters; i++)
        begin
            if (s >= 0)
            begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                s -= longint'(ANGLES[i]);
            end
            else
            begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                s += longint'(ANGLES[i]);
            end
            x = nx;
        end
        y = (y + 16384) >>> 15;
        if (y > 32767)
            y = 32767;
        if (y < -32767)
            y = -32767;
        return y;
    endfunction

    function automatic fields_t wave_fields(input logic [31:0] t, input logic [31:0] z);
        logic [63:0] ft;
        logic [63:0] zmag;
        logic [63:0] zq;
        logic [31:0] ang;
        longint      sn;
        fields_t     r;
        ft   = 64'(wave_cfg.frequency) * 64'(t);
        zmag = z[31] ? (64'h1_0000_0000 - 64'(z)) : 64'(z);
        zq   = (zmag << 32) / 64'(wave_cfg.wavelength);
        ang  = z[31] ? ft[31:0] + zq[31:0] : ft[31:0] - zq[31:0];
        ang += {wave_cfg.phase_turns, 16'd0};
        sn   = sine_of_turns(ang);
        r.e  = 17'((longint'(wave_cfg.amp_e) * sn + 16384) >>> 15);
        r.b  = 17'((longint'(wave_cfg.amp_b) * sn + 16384) >>> 15);
        return r;
    endfunction

    task automatic send_word(input logic [31:0] t, input logic [31:0] z);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        time_val <= t;
        position <= z;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        field_queue.push_back(wave_fields(t, z));
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (field_queue.size() != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
        case (idx)
            pwfe_pkg::REG_FREQUENCY:  if (data != 0) wave_cfg.frequency = data;
            pwfe_pkg::REG_WAVELENGTH: if (data != 0) wave_cfg.wavelength = data;
            pwfe_pkg::REG_AMP_E:      if (data[15:0] != 0) wave_cfg.amp_e = data[15:0];
            pwfe_pkg::REG_AMP_B:      if (data[15:0] != 0) wave_cfg.amp_b = data[15:0];
            pwfe_pkg::REG_PHASE:      wave_cfg.phase_turns = data[15:0];
            default:                  ;
        endcase
    endtask

    always @(posedge clk)
    begin
        fields_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (field_queue.size() == 0)
            begin
                $display("%0t: unexpected word e=%0d b=%0d", $time, e_field, b_field);
                error_count++;
            end
            else
            begin
                want = field_queue.pop_front();
                if (want.e !== e_field)
                begin
                    $display("%0t: e_field expected %0d actual %0d", $time, want.e, e_field);
                    error_count++;
                end
                if (want.b !== b_field)
                begin
                    $display("%0t: b_field expected %0d actual %0d", $time, want.b, b_field);
                    error_count++;
                end
            end
        end
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    task automatic test_directed;
        logic [31:0] t_edges[4] = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h0001_0000};
        logic [31:0] z_edges[5] = '{32'd0, 32'd1, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF};
        foreach (t_edges[i])
            foreach (z_edges[j])
                send_word(t_edges[i], z_edges[j]);
        send_word(32'h0000_4000, 32'd0);
        send_word(32'h0000_C000, 32'd0);
        send_word(32'h0000_8000, 32'd0);
        drain();
    endtask

    task automatic test_registers;
        write_reg(pwfe_pkg::REG_FREQUENCY, 32'd0);
        write_reg(pwfe_pkg::REG_WAVELENGTH, 32'd0);
        write_reg(pwfe_pkg::REG_AMP_E, 32'hFFFF_0000);
        write_reg(pwfe_pkg::REG_AMP_B, 32'd0);
        write_reg(3'd5, 32'h1234_5678);
        write_reg(3'd7, 32'hFFFF_FFFF);
        write_reg(pwfe_pkg::REG_AMP_E, 32'hABCD_FFFF);
        write_reg(pwfe_pkg::REG_AMP_B, 32'd1);
        write_reg(pwfe_pkg::REG_PHASE, 32'h0001_4000);
        write_reg(pwfe_pkg::REG_FREQUENCY, 32'hFFFF_FFFF);
        write_reg(pwfe_pkg::REG_WAVELENGTH, 32'd1);
        for (int i = 0; i < 10; i++)
            send_word($urandom, $urandom);
        drain();
    endtask

    task automatic random_phase(input int count, input int idle, input int stall);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        write_reg(pwfe_pkg::REG_FREQUENCY,
                  $urandom_range(1, 3) == 1 ? 32'd1 : $urandom | 32'd1);
        write_reg(pwfe_pkg::REG_WAVELENGTH,
                  $urandom_range(1, 4) == 1 ? 32'hFFFF_FFFF : $urandom | 32'd1);
        write_reg(pwfe_pkg::REG_AMP_E, $urandom_range(1, 65535));
        write_reg(pwfe_pkg::REG_AMP_B,
                  $urandom_range(1, 3) == 1 ? 32'd65535 : $urandom_range(1, 65535));
        write_reg(pwfe_pkg::REG_PHASE, $urandom_range(65535));
        for (int i = 0; i < count; i++)
        begin
            send_word($urandom, $urandom);
            if (i == count / 2)
            begin
                in_valid <= 1'b0;
                while (field_queue.size() != 0)
                    @(posedge clk);
            end
        end
        drain();
    endtask

    task automatic test_streaming;
        random_phase(300, 0, 0);
        random_phase(300, 57, 0);
        random_phase(300, 0, 57);
        random_phase(300, 37, 37);
        random_phase(300, $urandom_range(0, 30), $urandom_range(0, 30));
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        time_val = '0;
        position = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        error_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        wave_cfg = '{pwfe_pkg::FREQ_RST, pwfe_pkg::WAVE_RST, pwfe_pkg::AMP_RST,
                     pwfe_pkg::AMP_RST, pwfe_pkg::PHASE_RST};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_registers();
        test_streaming();
        if (error_count == 0 && field_queue.size() == 0)
            $display("** plane_wave_field_eval_core: PASSED **");
        else
            $display("** plane_wave_field_eval_core: FAILED **");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("** plane_wave_field_eval_core: FAILED **");
        $finish;
    end
endmodule

@@ files.f @@
hw/rtl/pwfe_pkg.sv
hw/rtl/pwfe_front.sv
hw/rtl/pwfe_queue.sv
hw/rtl/pwfe_back.sv
hw/rtl/plane_wave_field_eval_core.sv
bench/testbench.sv
